### rtl/core/sed_pkg.sv
// ----------------------------------------------------------------------------
// Sampson distance package
// Shared widths, register codes and transaction types for the Sampson
// epipolar distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

  localparam int COORD_W   = 16;  // Q4.12 point coordinate
  localparam int COEF_W    = 16;  // Q2.14 matrix coefficient
  localparam int ROW_W     = 48;  // one packed matrix row
  localparam int N_ROWS    = 3;
  localparam int PROD_W    = 32;  // coefficient times coordinate
  localparam int FXV_W     = 33;  // components of Fx and x'F
  localparam int MAG_W     = 32;  // magnitude of an Fx or x'F component
  localparam int SQ_W      = 64;  // square of such a component
  localparam int DEN_W     = 66;  // gradient sum
  localparam int RES_W     = 49;  // epipolar residual x'Fx
  localparam int RMAG_W    = 48;  // magnitude of the residual
  localparam int NSQ_W     = 96;  // square of the residual
  localparam int NUM_SHIFT = 8;   // Q.76 over Q.52 down to Q.16
  localparam int NUM_W     = NSQ_W - NUM_SHIFT;
  localparam int QUO_W     = 32;  // quotient bits, one per divider step
  localparam int ONE_SHIFT = 12;  // homogeneous one in Q4.12

  typedef enum logic [1:0] {
    REG_F_ROW0 = 2'd0,
    REG_F_ROW1 = 2'd1,
    REG_F_ROW2 = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
  } in_item_t;

  typedef struct packed {
    logic [QUO_W-1:0] distance;
    logic             zero_denominator;
  } out_item_t;

  typedef logic [N_ROWS-1:0][ROW_W-1:0] fmat_t;

  typedef struct packed {
    logic                    valid;
    logic signed [RES_W-1:0] resid;
    logic [DEN_W-1:0]        den;
  } grad_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] numr;
    logic [DEN_W-1:0] den;
  } quot_in_t;

endpackage

`default_nettype wire

### rtl/core/sed_grad.sv
// ----------------------------------------------------------------------------
// Sampson distance gradient stages
// Four register stages: coefficient products, Fx and x'F sums, squares and
// residual products, then the residual x'Fx and the gradient sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_grad
  import sed_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  input  wire fmat_t    f_rows,
  output grad_t         grad
);

  logic signed [COEF_W-1:0] coef_w [N_ROWS][N_ROWS];

  logic                      s1_valid_r;
  logic signed [PROD_W-1:0]  s1_pfx_r [N_ROWS][2];
  logic signed [PROD_W-1:0]  s1_pxf_r [2][2];
  logic signed [COEF_W-1:0]  s1_kfx_r [N_ROWS];
  logic signed [COEF_W-1:0]  s1_kxf_r [2];
  logic signed [COORD_W-1:0] s1_x2_r;
  logic signed [COORD_W-1:0] s1_y2_r;

  logic                      s2_valid_r;
  logic signed [FXV_W-1:0]   s2_fx_r [N_ROWS];
  logic signed [FXV_W-1:0]   s2_xf_r [2];
  logic signed [COORD_W-1:0] s2_x2_r;
  logic signed [COORD_W-1:0] s2_y2_r;

  logic signed [FXV_W-1:0]   neg_w [4];
  logic [MAG_W-1:0]          abs_w [4];

  logic                      s3_valid_r;
  logic [SQ_W-1:0]           s3_sq_r [4];
  logic signed [RES_W-1:0]   s3_pe_r [2];
  logic signed [RES_W-1:0]   s3_ke_r;

  grad_t                     grad_r;

  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      for (int c = 0; c < N_ROWS; c++) begin
        coef_w[r][c] = $signed(f_rows[r][c*COEF_W +: COEF_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < N_ROWS; r++) begin
      s1_pfx_r[r][0] <= PROD_W'(coef_w[r][0]) * PROD_W'($signed(in_item.first_x));
      s1_pfx_r[r][1] <= PROD_W'(coef_w[r][1]) * PROD_W'($signed(in_item.first_y));
      s1_kfx_r[r]    <= coef_w[r][2];
    end
    for (int c = 0; c < 2; c++) begin
      s1_pxf_r[c][0] <= PROD_W'($signed(in_item.second_x)) * PROD_W'(coef_w[0][c]);
      s1_pxf_r[c][1] <= PROD_W'($signed(in_item.second_y)) * PROD_W'(coef_w[1][c]);
      s1_kxf_r[c]    <= coef_w[2][c];
    end
    s1_x2_r <= in_item.second_x;
    s1_y2_r <= in_item.second_y;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < N_ROWS; r++) begin
      s2_fx_r[r] <= FXV_W'(s1_pfx_r[r][0]) + FXV_W'(s1_pfx_r[r][1])
                  + (FXV_W'(s1_kfx_r[r]) <<< ONE_SHIFT);
    end
    for (int c = 0; c < 2; c++) begin
      s2_xf_r[c] <= FXV_W'(s1_pxf_r[c][0]) + FXV_W'(s1_pxf_r[c][1])
                  + (FXV_W'(s1_kxf_r[c]) <<< ONE_SHIFT);
    end
    s2_x2_r <= s1_x2_r;
    s2_y2_r <= s1_y2_r;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg_w[i] = '0;
      abs_w[i] = '0;
    end
    neg_w[0] = -s2_fx_r[0];
    neg_w[1] = -s2_fx_r[1];
    neg_w[2] = -s2_xf_r[0];
    neg_w[3] = -s2_xf_r[1];
    abs_w[0] = s2_fx_r[0][FXV_W-1] ? neg_w[0][MAG_W-1:0] : s2_fx_r[0][MAG_W-1:0];
    abs_w[1] = s2_fx_r[1][FXV_W-1] ? neg_w[1][MAG_W-1:0] : s2_fx_r[1][MAG_W-1:0];
    abs_w[2] = s2_xf_r[0][FXV_W-1] ? neg_w[2][MAG_W-1:0] : s2_xf_r[0][MAG_W-1:0];
    abs_w[3] = s2_xf_r[1][FXV_W-1] ? neg_w[3][MAG_W-1:0] : s2_xf_r[1][MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s3_sq_r[i] <= SQ_W'(abs_w[i]) * SQ_W'(abs_w[i]);
    end
    s3_pe_r[0] <= RES_W'(s2_x2_r) * RES_W'(s2_fx_r[0]);
    s3_pe_r[1] <= RES_W'(s2_y2_r) * RES_W'(s2_fx_r[1]);
    s3_ke_r    <= RES_W'(s2_fx_r[2]) <<< ONE_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_r.valid <= 1'b0;
    end else begin
      grad_r.valid <= s3_valid_r;
    end
    grad_r.resid <= s3_pe_r[0] + s3_pe_r[1] + s3_ke_r;
    grad_r.den   <= DEN_W'(s3_sq_r[0]) + DEN_W'(s3_sq_r[1])
                  + DEN_W'(s3_sq_r[2]) + DEN_W'(s3_sq_r[3]);
  end

  assign grad = grad_r;

endmodule

`default_nettype wire

### rtl/core/sed_resq.sv
// ----------------------------------------------------------------------------
// Sampson distance residual square
// Two register stages: residual magnitude split into partial products,
// then the summed square scaled down to the divider's numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_resq
  import sed_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire grad_t grad,
  output quot_in_t   quot_in
);

  localparam int HI_W = RMAG_W - MAG_W;

  logic signed [RES_W-1:0]  neg_w;
  logic [RMAG_W-1:0]        abs_w;
  logic [HI_W-1:0]          hi_w;
  logic [MAG_W-1:0]         lo_w;

  logic                     s5_valid_r;
  logic [2*MAG_W-1:0]       s5_pll_r;
  logic [HI_W+MAG_W-1:0]    s5_phl_r;
  logic [2*HI_W-1:0]        s5_phh_r;
  logic [DEN_W-1:0]         s5_den_r;

  logic [NSQ_W-1:0]         nsq_nxt;
  quot_in_t                 quot_r;

  always_comb begin
    neg_w = -grad.resid;
    abs_w = grad.resid[RES_W-1] ? neg_w[RMAG_W-1:0] : grad.resid[RMAG_W-1:0];
    hi_w  = abs_w[RMAG_W-1:MAG_W];
    lo_w  = abs_w[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r    <= 1'b0;
    end else begin
      s5_valid_r    <= grad.valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_pll_r <= (2*MAG_W)'(lo_w) * (2*MAG_W)'(lo_w);
    s5_phl_r <= (HI_W+MAG_W)'(hi_w) * (HI_W+MAG_W)'(lo_w);
    s5_phh_r <= (2*HI_W)'(hi_w) * (2*HI_W)'(hi_w);
    s5_den_r <= grad.den;
  end

  assign nsq_nxt = NSQ_W'({s5_phh_r, {(2*MAG_W){1'b0}}})
                 + (NSQ_W'(s5_phl_r) << (MAG_W + 1))
                 + NSQ_W'(s5_pll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quot_r.valid  <= 1'b0;
    end else begin
      quot_r.valid  <= s5_valid_r;
    end
    quot_r.numr <= nsq_nxt[NSQ_W-1:NUM_SHIFT];
    quot_r.den  <= s5_den_r;
  end

  assign quot_in = quot_r;

endmodule

`default_nettype wire

### rtl/core/sed_div.sv
// ----------------------------------------------------------------------------
// Sampson distance divider
// Range check stage, one restoring quotient bit per register stage, then the
// saturating output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_div
  import sed_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire quot_in_t quot_in,
  output logic          out_valid,
  output out_item_t     out_item
);

  logic                 d_valid_r [QUO_W+1];
  logic [DEN_W-1:0]     d_rem_r   [QUO_W+1];
  logic [QUO_W-1:0]     d_low_r   [QUO_W+1];
  logic [QUO_W-1:0]     d_quo_r   [QUO_W+1];
  logic [DEN_W-1:0]     d_den_r   [QUO_W+1];
  logic                 d_zero_r  [QUO_W+1];
  logic                 d_ovf_r   [QUO_W+1];

  logic                 out_valid_r;
  out_item_t            out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r[0] <= 1'b0;
    end else begin
      d_valid_r[0] <= quot_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    d_rem_r[0]  <= DEN_W'(quot_in.numr[NUM_W-1:QUO_W]);
    d_low_r[0]  <= quot_in.numr[QUO_W-1:0];
    d_quo_r[0]  <= '0;
    d_den_r[0]  <= quot_in.den;
    d_zero_r[0] <= (quot_in.den == '0);
    d_ovf_r[0]  <= (DEN_W'(quot_in.numr[NUM_W-1:QUO_W]) >= quot_in.den);
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0]   trial_nxt;
    logic             ge_nxt;
    logic [DEN_W:0]   diff_nxt;
    logic [DEN_W-1:0] rem_nxt;

    always_comb begin
      trial_nxt = {d_rem_r[k], d_low_r[k][QUO_W-1]};
      ge_nxt    = (trial_nxt >= {1'b0, d_den_r[k]});
      diff_nxt  = trial_nxt - {1'b0, d_den_r[k]};
      rem_nxt   = ge_nxt ? diff_nxt[DEN_W-1:0] : trial_nxt[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_valid_r[k+1] <= 1'b0;
      end else begin
        d_valid_r[k+1] <= d_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      d_rem_r[k+1]  <= rem_nxt;
      d_low_r[k+1]  <= {d_low_r[k][QUO_W-2:0], 1'b0};
      d_quo_r[k+1]  <= {d_quo_r[k][QUO_W-2:0], ge_nxt};
      d_den_r[k+1]  <= d_den_r[k];
      d_zero_r[k+1] <= d_zero_r[k];
      d_ovf_r[k+1]  <= d_ovf_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_valid_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.distance         <= (d_zero_r[QUO_W] || d_ovf_r[QUO_W]) ? '1 : d_quo_r[QUO_W];
    out_item_r.zero_denominator <= d_zero_r[QUO_W];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### rtl/core/sampson_epipolar_distance.sv
// ----------------------------------------------------------------------------
// Sampson epipolar distance
// Scores one point correspondence against a fundamental matrix held in three
// row registers; result is unsigned Q16.16, saturated, with a flag for a zero
// gradient sum.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while busy is low; the 32 divider
// stages set the depth. busy is set while rst_n is low and clears on the
// clock edge that samples rst_n high; results cannot be held off, so
// nothing stalls. Reset clears matrix and pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module sampson_epipolar_distance
  import sed_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  output out_item_t              out_item,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [ROW_W-1:0]  cfg_wdata
);

  fmat_t    f_rows_r;
  logic     busy_r;
  logic     in_valid;
  grad_t    grad;
  quot_in_t quot_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_rows_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_F_ROW0: f_rows_r[0] <= cfg_wdata;
        REG_F_ROW1: f_rows_r[1] <= cfg_wdata;
        REG_F_ROW2: f_rows_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy     = busy_r;
  assign in_valid = start && !busy_r;

  sed_grad u_grad (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .f_rows   (f_rows_r),
    .grad     (grad)
  );

  sed_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .grad    (grad),
    .quot_in (quot_in)
  );

  sed_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .quot_in   (quot_in),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### sim/tb_sampson_epipolar_distance.sv
// ----------------------------------------------------------------------------
// Sampson epipolar distance testbench
// Drives point correspondences through the command port under several matrix
// settings and scores every result against an exact wide-integer prediction
// of Fx, x'F, the residual and the saturated Q16.16 quotient.
// ----------------------------------------------------------------------------
module tb_sampson_epipolar_distance;
  import sed_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam longint HOM_ONE = longint'(1) << ONE_SHIFT;
  localparam logic [COEF_W-1:0] V_MIN = 16'h8000;
  localparam logic [COEF_W-1:0] V_MAX = 16'h7FFF;
  localparam logic [COEF_W-1:0] V_NEG1 = 16'hFFFF;
  localparam logic [COEF_W-1:0] V_ONE = 16'h0001;
  localparam logic [COEF_W-1:0] V_UNIT = 16'h4000;

  typedef enum int {VK_FULL, VK_SMALL, VK_EDGE} val_kind_t;
  typedef enum int {MAT_FULL, MAT_SMALL, MAT_EDGE, MAT_SKEW} mat_style_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_valid;
  out_item_t         out_item;
  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic [ROW_W-1:0]  cfg_wdata;

  logic [ROW_W-1:0]  f_rows [N_ROWS];
  out_item_t         dist_expect_q [$];
  int                err_cnt;
  int                gap_pct;
  mat_style_t        cur_mat;

  sampson_epipolar_distance uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint coef_at(int r, int c);
    logic signed [COEF_W-1:0] cf;
    cf = f_rows[r][COEF_W*c +: COEF_W];
    return longint'(cf);
  endfunction

  function automatic logic [127:0] square_mag(longint v);
    logic [127:0] m;
    m = (v < 0) ? 128'(-v) : 128'(v);
    return m * m;
  endfunction

  function automatic out_item_t sampson_predict(in_item_t pt);
    longint x1, y1, x2, y2;
    longint fx0, fx1, fx2, xf0, xf1, resid;
    logic [127:0] num, den, quo;
    out_item_t res;
    x1 = longint'(pt.first_x);
    y1 = longint'(pt.first_y);
    x2 = longint'(pt.second_x);
    y2 = longint'(pt.second_y);
    fx0 = coef_at(0, 0) * x1 + coef_at(0, 1) * y1 + coef_at(0, 2) * HOM_ONE;
    fx1 = coef_at(1, 0) * x1 + coef_at(1, 1) * y1 + coef_at(1, 2) * HOM_ONE;
    fx2 = coef_at(2, 0) * x1 + coef_at(2, 1) * y1 + coef_at(2, 2) * HOM_ONE;
    xf0 = x2 * coef_at(0, 0) + y2 * coef_at(1, 0) + coef_at(2, 0) * HOM_ONE;
    xf1 = x2 * coef_at(0, 1) + y2 * coef_at(1, 1) + coef_at(2, 1) * HOM_ONE;
    resid = x2 * fx0 + y2 * fx1 + fx2 * HOM_ONE;
    num = square_mag(resid);
    den = square_mag(fx0) + square_mag(fx1) + square_mag(xf0) + square_mag(xf1);
    res.distance = '1;
    res.zero_denominator = 1'b0;
    if (den == 0) begin
      res.zero_denominator = 1'b1;
    end else begin
      quo = num / (den << NUM_SHIFT);
      if (quo <= 128'hFFFF_FFFF) begin
        res.distance = quo[QUO_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [COEF_W-1:0] rand_val16(val_kind_t k);
    logic [COEF_W-1:0] v;
    case (k)
      VK_SMALL: v = 16'(int'($urandom_range(0, 512)) - 256);
      VK_EDGE: begin
        case ($urandom_range(0, 5))
          0: v = V_MIN;
          1: v = V_MAX;
          2: v = V_NEG1;
          3: v = '0;
          4: v = V_ONE;
          default: v = V_UNIT;
        endcase
      end
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] c0,
                                                logic [COEF_W-1:0] c1,
                                                logic [COEF_W-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic in_item_t make_point(logic [COEF_W-1:0] x1, logic [COEF_W-1:0] y1,
                                          logic [COEF_W-1:0] x2, logic [COEF_W-1:0] y2);
    in_item_t p;
    p.first_x = x1;
    p.first_y = y1;
    p.second_x = x2;
    p.second_y = y2;
    return p;
  endfunction

  function automatic in_item_t pick_point();
    in_item_t p;
    val_kind_t k;
    int sel;
    sel = $urandom_range(0, 9);
    k = (sel < 4) ? VK_FULL : (sel < 8) ? VK_SMALL : VK_EDGE;
    p = make_point(rand_val16(k), rand_val16(k), rand_val16(k), rand_val16(k));
    if ((cur_mat == MAT_SKEW && sel < 7) || sel == 9) begin
      p.second_x = p.first_x + 16'(int'($urandom_range(0, 64)) - 32);
      p.second_y = p.first_y + 16'(int'($urandom_range(0, 64)) - 32);
    end
    return p;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (dist_expect_q.size() == 0) begin
        err_cnt++;
        if (err_cnt < 60)
          $display("%0t: unexpected result, expected none, actual %h/%b",
                   $realtime, out_item.distance, out_item.zero_denominator);
      end else begin
        exp_r = dist_expect_q.pop_front();
        if (out_item.distance !== exp_r.distance) begin
          err_cnt++;
          if (err_cnt < 60)
            $display("%0t: distance expected %h actual %h",
                     $realtime, exp_r.distance, out_item.distance);
        end
        if (out_item.zero_denominator !== exp_r.zero_denominator) begin
          err_cnt++;
          if (err_cnt < 60)
            $display("%0t: zero_denominator expected %b actual %b",
                     $realtime, exp_r.zero_denominator, out_item.zero_denominator);
        end
      end
    end
  end

  task automatic send_point(in_item_t pt);
    start = 1'b1;
    in_item = pt;
    do @(posedge clk); while (busy);
    dist_expect_q.push_back(sampson_predict(pt));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic idle_burst();
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct)
      repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [ROW_W-1:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(posedge clk);
    if (idx <= REG_F_ROW2)
      f_rows[idx] = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_results_done();
    while (dist_expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_matrix(mat_style_t s);
    logic [COEF_W-1:0] c [9];
    logic [COEF_W-1:0] a, b, g;
    val_kind_t k;
    cur_mat = s;
    if (s == MAT_SKEW) begin
      a = rand_val16(VK_FULL);
      b = rand_val16(VK_FULL);
      g = rand_val16(VK_FULL);
      if (a == V_MIN) a = V_MAX;
      if (b == V_MIN) b = V_MAX;
      if (g == V_MIN) g = V_MAX;
      c = '{16'h0, -g, b, g, 16'h0, -a, -b, a, 16'h0};
    end else begin
      for (int i = 0; i < 9; i++) begin
        k = (s == MAT_SMALL) ? VK_SMALL : VK_FULL;
        if (s == MAT_EDGE && $urandom_range(0, 1) == 0)
          k = VK_EDGE;
        c[i] = rand_val16(k);
      end
    end
    if ($urandom_range(0, 3) == 0)
      write_cfg(REG_NONE, {$urandom(), $urandom()});
    write_cfg(REG_F_ROW0, pack_row(c[0], c[1], c[2]));
    write_cfg(REG_F_ROW1, pack_row(c[3], c[4], c[5]));
    write_cfg(REG_F_ROW2, pack_row(c[6], c[7], c[8]));
  endtask

  task automatic test_reset_matrix();
    send_point(make_point(V_MIN, V_MAX, V_NEG1, V_ONE));
    send_point(make_point(V_MAX, V_MIN, V_ONE, V_NEG1));
  endtask

  task automatic test_ignored_index();
    wait_results_done();
    write_cfg(REG_NONE, '1);
    send_point(make_point(V_MAX, V_MAX, V_MAX, V_MAX));
    wait_results_done();
  endtask

  task automatic test_saturation();
    write_cfg(REG_F_ROW0, pack_row(V_ONE, 16'h0, 16'h0));
    write_cfg(REG_F_ROW2, pack_row(16'h0, 16'h0, V_MAX));
    send_point(make_point(V_ONE, 16'h0, V_ONE, 16'h0));
    send_point(make_point(16'h0, 16'h0, 16'h0, 16'h0));
    send_point(make_point(V_MAX, V_MIN, V_MIN, V_MAX));
    wait_results_done();
  endtask

  task automatic test_zero_residual();
    write_cfg(REG_F_ROW0, pack_row(V_UNIT, 16'h0, 16'h0));
    write_cfg(REG_F_ROW1, '0);
    write_cfg(REG_F_ROW2, '0);
    send_point(make_point(16'h0, 16'h04D2, 16'h1000, 16'hFFB3));
    send_point(make_point(16'h0, V_MIN, V_MIN, V_MAX));
    wait_results_done();
  endtask

  task automatic test_extremes();
    for (int m = 0; m < 2; m++) begin
      a_row: begin
        logic [COEF_W-1:0] cv;
        cv = (m == 0) ? V_MIN : V_MAX;
        write_cfg(REG_F_ROW0, pack_row(cv, cv, cv));
        write_cfg(REG_F_ROW1, pack_row(cv, cv, cv));
        write_cfg(REG_F_ROW2, pack_row(cv, cv, cv));
      end
      send_point(make_point(V_MIN, V_MIN, V_MIN, V_MIN));
      send_point(make_point(V_MAX, V_MAX, V_MAX, V_MAX));
      send_point(make_point(V_MIN, V_MAX, V_MAX, V_MIN));
      send_point(make_point(16'h0, 16'h0, 16'h0, 16'h0));
      wait_results_done();
    end
  endtask

  task automatic test_hold_off();
    load_matrix(MAT_FULL);
    gap_pct = 30;
    repeat (20) begin
      send_point(pick_point());
      idle_burst();
    end
    wait_results_done();
    repeat (20) send_point(pick_point());
  endtask

  task automatic test_random_sweep();
    mat_style_t s;
    for (int ph = 0; ph < 8; ph++) begin
      wait_results_done();
      s = (ph < 4) ? mat_style_t'(ph) : mat_style_t'($urandom_range(0, 3));
      load_matrix(s);
      case (ph % 3)
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 45;
      endcase
      repeat (105) begin
        send_point(pick_point());
        idle_burst();
      end
    end
  endtask

  task automatic test_back_to_back();
    wait_results_done();
    load_matrix(MAT_FULL);
    gap_pct = 0;
    repeat (120) send_point(pick_point());
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    err_cnt = 0;
    gap_pct = 0;
    cur_mat = MAT_FULL;
    for (int r = 0; r < N_ROWS; r++)
      f_rows[r] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_matrix();
    test_ignored_index();
    test_saturation();
    test_zero_residual();
    test_extremes();
    test_hold_off();
    test_random_sweep();
    test_back_to_back();

    wait_results_done();
    repeat (48) @(posedge clk);
    if (err_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
